// File: rtl/dcpll_pkg.sv
// ----------------------------------------------------------------------------
// dcpll_pkg
// Shared types, constants and tables of the decision-directed carrier loop.
// ----------------------------------------------------------------------------
package dcpll_pkg;

	// default sizes handed to the top level
	localparam int DEF_SAMPLE_WIDTH  = 16;
	localparam int DEF_PHASE_WIDTH   = 24;
	localparam int DEF_CORDIC_STAGES = 16;

	// CORDIC data carry guard bits plus headroom for gain and quadrant fold
	localparam int GUARD_BITS = 8;
	localparam int CDC_HEAD   = GUARD_BITS + 3;

	// inverse CORDIC gain, Q0.16, and multiplier operand width for gains
	localparam int GAIN_W            = 17;
	localparam logic [15:0] INV_GAIN = 16'd39797;

	// arctangent table in 2^-32 turn
	localparam int ATAN_N  = 24;
	localparam int ATAN_IW = 5;
	localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int FREQ_W = 24;

	typedef enum logic [2:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_FREQ_MIN     = 3'd2,
		REG_FREQ_MAX     = 3'd3,
		REG_ORDER_LOG2   = 3'd4,
		REG_POINT_OFFSET = 3'd5
	} reg_idx_t;

	localparam logic [15:0]       RST_PROP_GAIN    = 16'd0;
	localparam logic [15:0]       RST_INTEG_GAIN   = 16'd0;
	localparam logic [FREQ_W-1:0] RST_FREQ_MIN     = 24'h80_0000;
	localparam logic [FREQ_W-1:0] RST_FREQ_MAX     = 24'h7F_FFFF;
	localparam logic [2:0]        RST_ORDER_LOG2   = 3'd2;
	localparam logic [15:0]       RST_POINT_OFFSET = 16'd8192;

	// register file contents seen by the datapath
	typedef struct packed {
		logic [15:0]       prop_gain;
		logic [15:0]       integ_gain;
		logic [FREQ_W-1:0] freq_min;
		logic [FREQ_W-1:0] freq_max;
		logic [2:0]        order_log2;
		logic [15:0]       point_offset;
	} cfg_t;

	// commands to the shared CORDIC unit
	typedef struct packed {
		logic load_rot;
		logic load_vec;
		logic step;
	} cdc_ctrl_t;

endpackage

// File: rtl/dcpll_regs.sv
// ----------------------------------------------------------------------------
// dcpll_regs
// APB-style configuration registers of the carrier loop.
// ----------------------------------------------------------------------------
module dcpll_regs import dcpll_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg    = cfg_q;

	// write one register per access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain    <= RST_PROP_GAIN;
			cfg_q.integ_gain   <= RST_INTEG_GAIN;
			cfg_q.freq_min     <= RST_FREQ_MIN;
			cfg_q.freq_max     <= RST_FREQ_MAX;
			cfg_q.order_log2   <= RST_ORDER_LOG2;
			cfg_q.point_offset <= RST_POINT_OFFSET;
		end else if (wr_en) begin
			case (idx)
				REG_PROP_GAIN:    cfg_q.prop_gain    <= pwdata[15:0];
				REG_INTEG_GAIN:   cfg_q.integ_gain   <= pwdata[15:0];
				REG_FREQ_MIN:     cfg_q.freq_min     <= pwdata[FREQ_W-1:0];
				REG_FREQ_MAX:     cfg_q.freq_max     <= pwdata[FREQ_W-1:0];
				REG_ORDER_LOG2:   cfg_q.order_log2   <= pwdata[2:0];
				REG_POINT_OFFSET: cfg_q.point_offset <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// return the addressed register, zero-extended
	always_comb begin
		case (idx)
			REG_PROP_GAIN:    prdata = DATA_W'(cfg_q.prop_gain);
			REG_INTEG_GAIN:   prdata = DATA_W'(cfg_q.integ_gain);
			REG_FREQ_MIN:     prdata = DATA_W'(cfg_q.freq_min);
			REG_FREQ_MAX:     prdata = DATA_W'(cfg_q.freq_max);
			REG_ORDER_LOG2:   prdata = DATA_W'(cfg_q.order_log2);
			REG_POINT_OFFSET: prdata = DATA_W'(cfg_q.point_offset);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: rtl/dcpll_cordic.sv
// ----------------------------------------------------------------------------
// dcpll_cordic
// One CORDIC micro-rotation unit, shared by rotation and vectoring modes.
// ----------------------------------------------------------------------------
module dcpll_cordic import dcpll_pkg::*; #(
	parameter int SAMPLE_WIDTH  = DEF_SAMPLE_WIDTH,
	parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cdc_ctrl_t                              ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0]         ld_x,
	input  logic signed [SAMPLE_WIDTH-1:0]         ld_y,
	input  logic [31:0]                            ld_ang,
	output logic signed [SAMPLE_WIDTH+CDC_HEAD-1:0] x,
	output logic signed [SAMPLE_WIDTH+CDC_HEAD-1:0] y,
	output logic [31:0]                            z,
	output logic                                   last
);

	localparam int DW   = SAMPLE_WIDTH + CDC_HEAD;
	localparam int NSTG = (CORDIC_STAGES > ATAN_N) ? ATAN_N : CORDIC_STAGES;
	localparam int CW   = $clog2(NSTG);

	logic signed [DW-1:0] x_q, y_q, x0, y0, dx, dy;
	logic [31:0]          z_q, ang_p, rz, atan;
	logic [1:0]           quad;
	logic [CW-1:0]        cnt_q;
	logic                 rot_q, ccw;

	// scale the loaded sample up by the guard bits
	assign x0 = DW'(ld_x) <<< GUARD_BITS;
	assign y0 = DW'(ld_y) <<< GUARD_BITS;

	// fold the rotation angle into the nearest quadrant
	assign ang_p = ld_ang + 32'h2000_0000;
	assign quad  = ang_p[31:30];
	assign rz    = ld_ang - {quad, 30'd0};

	// micro-rotation operands and direction
	assign dx   = y_q >>> cnt_q;
	assign dy   = x_q >>> cnt_q;
	assign atan = ATAN_TAB[ATAN_IW'(cnt_q)];
	assign ccw  = rot_q ? !z_q[31] : (y_q[DW-1] || (y_q == '0));

	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;
	assign last = (cnt_q == CW'(NSTG - 1));

	// track mode and stage index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= 1'b1;
			cnt_q <= '0;
		end else if (ctrl.load_rot || ctrl.load_vec) begin
			rot_q <= ctrl.load_rot;
			cnt_q <= '0;
		end else if (ctrl.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// load, then rotate by one stage per cycle while step is asserted
	always_ff @(posedge clk) begin
		if (ctrl.load_rot) begin
			z_q <= rz;
			case (quad)
				2'd1: begin
					x_q <= -y0;
					y_q <= x0;
				end
				2'd2: begin
					x_q <= -x0;
					y_q <= -y0;
				end
				2'd3: begin
					x_q <= y0;
					y_q <= -x0;
				end
				default: begin
					x_q <= x0;
					y_q <= y0;
				end
			endcase
		end else if (ctrl.load_vec) begin
			if (x0[DW-1]) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= 32'h8000_0000;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (ctrl.step) begin
			if (ccw) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan;
			end
		end
	end

endmodule

// File: rtl/decision_directed_carrier_pll_top.sv
// ----------------------------------------------------------------------------
// decision_directed_carrier_pll_top
// Decision-directed M-PSK carrier recovery loop with a shared CORDIC unit.
// ----------------------------------------------------------------------------
// Each sample is handled by the single CORDIC micro-rotation unit: it first
// de-rotates the sample by the loop phase, then measures the angle of the
// scaled result; each pass runs CORDIC_STAGES micro-rotations, capped at 24.
// One shared multiplier applies the inverse CORDIC gain between the two
// passes and the two loop gains after the second. One sample is in flight at
// a time. A finished result waits in the output register while the next
// sample is taken; the loop update of that next sample holds until the
// previous result has been taken.
// ----------------------------------------------------------------------------
module decision_directed_carrier_pll_top import dcpll_pkg::*; #(
	parameter int SAMPLE_WIDTH  = DEF_SAMPLE_WIDTH,
	parameter int PHASE_WIDTH   = DEF_PHASE_WIDTH,
	parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ADDR_W-1:0]              paddr,
	input  logic [DATA_W-1:0]              pwdata,
	output logic [DATA_W-1:0]              prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] in_i,
	input  logic signed [SAMPLE_WIDTH-1:0] in_q,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] out_i,
	output logic signed [SAMPLE_WIDTH-1:0] out_q,
	output logic signed [15:0]             phase_error,
	output logic signed [FREQ_W-1:0]       loop_freq
);

	localparam int DW   = SAMPLE_WIDTH + CDC_HEAD;
	localparam int PRW  = DW + GAIN_W;
	localparam int FW   = FREQ_W + 1;
	localparam int SUMW = 35;
	localparam int SCALE_SH = 16 + GUARD_BITS;
	localparam int FREQ_SH  = 8;
	localparam logic signed [PRW-1:0] SC_RND = PRW'(1) <<< (SCALE_SH - 1);
	localparam logic signed [PRW-1:0] SMAX   = PRW'((1 << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [PRW-1:0] SMIN   = -SMAX - PRW'(1);
	localparam logic [2:0] ORDER_MIN = 3'd1;
	localparam logic [2:0] ORDER_MAX = 3'd4;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_ROT  = 11'b000_0000_0010,
		S_SCX  = 11'b000_0000_0100,
		S_SCY  = 11'b000_0000_1000,
		S_SQ   = 11'b000_0001_0000,
		S_VLD  = 11'b000_0010_0000,
		S_VEC  = 11'b000_0100_0000,
		S_ERR  = 11'b000_1000_0000,
		S_MB   = 11'b001_0000_0000,
		S_FRQ  = 11'b010_0000_0000,
		S_DONE = 11'b100_0000_0000
	} state_t;

	state_t                          state_q;
	cfg_t                            cfg;
	cdc_ctrl_t                       cdc_ctrl;
	logic signed [DW-1:0]            cx, cy, mul_a;
	logic signed [GAIN_W-1:0]        mul_b;
	logic [31:0]                     cz, ang, zr;
	logic                            cdc_last;
	logic signed [SAMPLE_WIDTH-1:0]  ld_x, ld_y, oi_q, oq_q;
	logic signed [PRW-1:0]           prod_q, rnd, scaled, bshift;
	logic [PHASE_WIDTH-1:0]          phase_acc_q;
	logic signed [FREQ_W-1:0]        freq_acc_q;
	logic signed [FW-1:0]            f_q, f_next, fmin_x, fmax_x, f_clamp;
	logic signed [15:0]              err_q, err_next;
	logic [15:0]                     ang16, dang, wsec, wmask, whalf;
	logic [2:0]                      lc;
	logic signed [SUMW-1:0]          fsum;
	logic signed [SUMW-1:0]          inc;
	logic                            accept, done_go, out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]  out_i_q, out_q_q;
	logic signed [15:0]              out_err_q;

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_s(
		input logic signed [PRW-1:0] v
	);
		logic signed [PRW-1:0] t;
		begin
			t = v;
			if (t > SMAX) begin
				t = SMAX;
			end else if (t < SMIN) begin
				t = SMIN;
			end
			return t[SAMPLE_WIDTH-1:0];
		end
	endfunction

	dcpll_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dcpll_cordic #(
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cdc_ctrl),
		.ld_x   (ld_x),
		.ld_y   (ld_y),
		.ld_ang (ang),
		.x      (cx),
		.y      (cy),
		.z      (cz),
		.last   (cdc_last)
	);

	// handshake
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign done_go   = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_i     = out_i_q;
	assign out_q     = out_q_q;
	assign phase_error = out_err_q;
	assign loop_freq   = freq_acc_q;

	// drive the CORDIC: rotate the new sample, then measure the scaled one
	assign cdc_ctrl.load_rot = accept;
	assign cdc_ctrl.load_vec = (state_q == S_VLD);
	assign cdc_ctrl.step     = (state_q == S_ROT) || (state_q == S_VEC);
	assign ld_x = (state_q == S_VLD) ? oi_q : in_i;
	assign ld_y = (state_q == S_VLD) ? oq_q : in_q;
	assign ang  = 32'd0 - (32'(phase_acc_q) << (32 - PHASE_WIDTH));

	// pick multiplier operands per step
	always_comb begin
		case (state_q)
			S_SCY: begin
				mul_a = cy;
				mul_b = GAIN_W'(INV_GAIN);
			end
			S_MB: begin
				mul_a = DW'(err_q);
				mul_b = GAIN_W'(cfg.integ_gain);
			end
			S_FRQ: begin
				mul_a = DW'(err_q);
				mul_b = GAIN_W'(cfg.prop_gain);
			end
			default: begin
				mul_a = cx;
				mul_b = GAIN_W'(INV_GAIN);
			end
		endcase
	end

	// round away the guard bits and gain, before saturation
	assign rnd    = prod_q + SC_RND;
	assign scaled = rnd >>> SCALE_SH;

	// slice by angle: nearest point gives the wrapped error
	assign zr       = cz + 32'h0000_8000;
	assign ang16    = ((oi_q == '0) && (oq_q == '0)) ? 16'd0 : zr[31:16];
	assign lc       = (cfg.order_log2 < ORDER_MIN) ? ORDER_MIN :
	                  (cfg.order_log2 > ORDER_MAX) ? ORDER_MAX : cfg.order_log2;
	assign wsec     = 16'd1 << (5'd16 - 5'(lc));
	assign wmask    = wsec - 16'd1;
	assign whalf    = wsec >> 1;
	assign dang     = ang16 - cfg.point_offset;
	assign err_next = $signed((dang + whalf) & wmask) - $signed(whalf);

	// integrate beta times error
	assign bshift = prod_q >>> FREQ_SH;
	assign f_next = FW'(freq_acc_q) + bshift[FW-1:0];

	// phase step and frequency clamp
	assign fsum   = (SUMW'(f_q) <<< 8) + prod_q[SUMW-1:0];
	assign inc    = fsum >>> (32 - PHASE_WIDTH);
	assign fmin_x = FW'($signed(cfg.freq_min));
	assign fmax_x = FW'($signed(cfg.freq_max));
	assign f_clamp = (f_q > fmax_x) ? fmax_x : (f_q < fmin_x) ? fmin_x : f_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= S_ROT;
				S_ROT:  if (cdc_last) state_q <= S_SCX;
				S_SCX:  state_q <= S_SCY;
				S_SCY:  state_q <= S_SQ;
				S_SQ:   state_q <= S_VLD;
				S_VLD:  state_q <= S_VEC;
				S_VEC:  if (cdc_last) state_q <= S_ERR;
				S_ERR:  state_q <= S_MB;
				S_MB:   state_q <= S_FRQ;
				S_FRQ:  state_q <= S_DONE;
				S_DONE: if (done_go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// loop state and output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			freq_acc_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (done_go) begin
				phase_acc_q <= phase_acc_q + inc[PHASE_WIDTH-1:0];
				freq_acc_q  <= f_clamp[FREQ_W-1:0];
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == S_SCX) || (state_q == S_SCY) ||
		    (state_q == S_MB) || (state_q == S_FRQ)) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == S_SCY) begin
			oi_q <= sat_s(scaled);
		end
		if (state_q == S_SQ) begin
			oq_q <= sat_s(scaled);
		end
		if (state_q == S_ERR) begin
			err_q <= err_next;
		end
		if (state_q == S_FRQ) begin
			f_q <= f_next;
		end
		if (done_go) begin
			out_i_q   <= oi_q;
			out_q_q   <= oq_q;
			out_err_q <= err_q;
		end
	end

	// a new result appears only from the final step
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the final step");

	// the loop phase moves only when a result is released
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done_go |=> $stable(phase_acc_q) && $stable(freq_acc_q))
		else $error("loop state changed without a released result");

	// an accepted request starts the de-rotation
	a_accept_rot: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_ROT))
		else $error("accepted request did not start rotation");

	// vectoring starts only after both scaled components are stored
	a_vec_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VLD) |-> $past(state_q == S_SQ))
		else $error("vectoring loaded out of order");

endmodule

// File: test/decision_directed_carrier_pll_top_test.sv
// ----------------------------------------------------------------------------
// decision_directed_carrier_pll_top_test
// Self-checking bench for the M-PSK carrier recovery loop. Requests are driven
// from a queue of pending samples, a bit-true loop predictor works out each
// result as its request is taken, and every result is compared field by field.
// The loop is run through several register settings, including the extremes.
// ----------------------------------------------------------------------------
module decision_directed_carrier_pll_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dcpll_pkg::*;

	localparam int  SW            = DEF_SAMPLE_WIDTH;
	localparam int  PH_W          = DEF_PHASE_WIDTH;
	localparam int  NSTG          = (DEF_CORDIC_STAGES > 24) ? 24 : DEF_CORDIC_STAGES;
	localparam int  SMAX          = 2 ** (SW - 1) - 1;
	localparam int  SMIN          = -(2 ** (SW - 1));
	localparam int  CYCLE_LIMIT   = 500000;
	localparam int  SETTLE_CYCLES = 100;
	localparam real TWO_PI        = 6.283185307179586;

	typedef struct packed {
		logic signed [SW-1:0] re;
		logic signed [SW-1:0] im;
	} sample_t;

	typedef struct packed {
		logic signed [SW-1:0]     rot_i;
		logic signed [SW-1:0]     rot_q;
		logic signed [15:0]       err;
		logic signed [FREQ_W-1:0] freq;
	} derot_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     psel      = 1'b0;
	logic                     penable   = 1'b0;
	logic                     pwrite    = 1'b0;
	logic [ADDR_W-1:0]        paddr     = '0;
	logic [DATA_W-1:0]        pwdata    = '0;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic signed [SW-1:0]     in_i      = '0;
	logic signed [SW-1:0]     in_q      = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [SW-1:0]     out_i;
	logic signed [SW-1:0]     out_q;
	logic signed [15:0]       phase_error;
	logic signed [FREQ_W-1:0] loop_freq;

	// loop state and register copies of the predictor
	logic [PH_W-1:0] nco_phase   = '0;
	longint          nco_freq    = 0;
	logic [15:0]     gain_p      = RST_PROP_GAIN;
	logic [15:0]     gain_i      = RST_INTEG_GAIN;
	longint          freq_lo     = longint'($signed(RST_FREQ_MIN));
	longint          freq_hi     = longint'($signed(RST_FREQ_MAX));
	logic [2:0]      order_sel   = RST_ORDER_LOG2;
	logic [15:0]     offset_turn = RST_POINT_OFFSET;

	sample_t pending [$];
	derot_t  derot_q [$];
	sample_t next_sample;
	derot_t  want;
	logic    req_taken   = 1'b0;
	int      idle_odds   = 6;
	int      send_gap    = 0;
	int      hold_gap    = 0;
	int      fault_count = 0;
	int      n_samples   = 0;
	int      n_results   = 0;
	int      n_settings  = 0;
	int      n_reads     = 0;
	int      cycle_count = 0;
	real     carrier_turn = 0.0;
	real     carrier_step = 0.0;

	decision_directed_carrier_pll_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_i        (in_i),
		.in_q        (in_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_i       (out_i),
		.out_q       (out_q),
		.phase_error (phase_error),
		.loop_freq   (loop_freq)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// micro-rotation angles, 2^-32 turn
	function automatic longint atan_step(input int k);
		case (k)
			0:  return 64'd536870912;
			1:  return 64'd316933406;
			2:  return 64'd167458907;
			3:  return 64'd85004756;
			4:  return 64'd42667331;
			5:  return 64'd21354465;
			6:  return 64'd10679838;
			7:  return 64'd5340245;
			8:  return 64'd2670163;
			9:  return 64'd1335087;
			10: return 64'd667544;
			11: return 64'd333772;
			12: return 64'd166886;
			13: return 64'd83443;
			14: return 64'd41722;
			15: return 64'd20861;
			16: return 64'd10430;
			17: return 64'd5215;
			18: return 64'd2608;
			19: return 64'd1304;
			20: return 64'd652;
			21: return 64'd326;
			22: return 64'd163;
			default: return 64'd81;
		endcase
	endfunction

	// rotate (x, y) anticlockwise by ang in 2^-32 turn; the CORDIC gain stays in
	function automatic void cordic_turn(inout longint x, inout longint y,
			input logic [31:0] ang);
		logic [31:0] quad;
		logic [31:0] rem;
		longint      z;
		longint      t;
		longint      dx;
		longint      dy;
		int          k;
		quad = ((ang + 32'h2000_0000) >> 30) & 32'd3;
		rem  = ang - (quad << 30);
		z    = longint'($signed(rem));
		// fold the quarter turn first
		case (quad)
			32'd1: begin
				t = x;
				x = -y;
				y = t;
			end
			32'd2: begin
				x = -x;
				y = -y;
			end
			32'd3: begin
				t = x;
				x = y;
				y = -t;
			end
			default: ;
		endcase
		for (k = 0; k < NSTG; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_step(k);
			end else begin
				x += dx;
				y -= dy;
				z += atan_step(k);
			end
		end
	endfunction

	// angle of (x, y) in 2^-16 turn, rounded half up
	function automatic logic [15:0] cordic_measure_angle(input longint x0, input longint y0);
		longint      x;
		longint      y;
		longint      z;
		longint      dx;
		longint      dy;
		logic [31:0] base;
		logic [31:0] rounded;
		int          k;
		if (x0 == 0 && y0 == 0)
			return 16'd0;
		x    = x0 * 256;
		y    = y0 * 256;
		z    = 0;
		base = 32'd0;
		// move the left half plane over by half a turn
		if (x < 0) begin
			x    = -x;
			y    = -y;
			base = 32'h8000_0000;
		end
		for (k = 0; k < NSTG; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += atan_step(k);
			end else begin
				x -= dx;
				y += dy;
				z -= atan_step(k);
			end
		end
		base    = base + z[31:0];
		rounded = base + 32'h0000_8000;
		return rounded[31:16];
	endfunction

	// drop the CORDIC gain, round half up and saturate to the sample width
	function automatic longint scale_round_sat(input longint v);
		longint s;
		s = (v * 39797 + 64'sd8388608) >>> 24;
		if (s > SMAX)
			s = SMAX;
		if (s < SMIN)
			s = SMIN;
		return s;
	endfunction

	// one loop step: de-rotate, slice, then update frequency and phase
	function automatic derot_t track_sample(input sample_t smp);
		longint      x;
		longint      y;
		longint      oi;
		longint      oq;
		longint      err;
		longint      f;
		longint      inc;
		logic [31:0] ang;
		logic [15:0] d;
		int          lg;
		int unsigned w;
		derot_t      r;
		x   = longint'(smp.re) * 256;
		y   = longint'(smp.im) * 256;
		ang = 32'd0 - (32'(nco_phase) << (32 - PH_W));
		cordic_turn(x, y, ang);
		oi = scale_round_sat(x);
		oq = scale_round_sat(y);

		// sector width from the clamped order
		lg = int'(order_sel);
		if (lg < 1)
			lg = 1;
		if (lg > 4)
			lg = 4;
		w   = 32'd1 << (16 - lg);
		d   = cordic_measure_angle(oi, oq) - offset_turn;
		err = longint'((32'(d) + (w >> 1)) & (w - 32'd1)) - longint'(w >> 1);

		// advance by the unclamped frequency, then clamp what is kept
		f         = nco_freq + ((longint'(gain_i) * err) >>> 8);
		inc       = (f * 256 + longint'(gain_p) * err) >>> (32 - PH_W);
		nco_phase = nco_phase + inc[PH_W-1:0];
		if (f > freq_hi)
			f = freq_hi;
		else if (f < freq_lo)
			f = freq_lo;
		nco_freq = f;

		r.rot_i = oi[SW-1:0];
		r.rot_q = oq[SW-1:0];
		r.err   = err[15:0];
		r.freq  = f[FREQ_W-1:0];
		return r;
	endfunction

	// write a register, mirror it in the predictor, then read it back
	task automatic reg_program(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		logic [DATA_W-1:0] mask;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(int'(idx) * 4);
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_PROP_GAIN:    gain_p      = val[15:0];
			REG_INTEG_GAIN:   gain_i      = val[15:0];
			REG_FREQ_MIN:     freq_lo     = longint'($signed(val[FREQ_W-1:0]));
			REG_FREQ_MAX:     freq_hi     = longint'($signed(val[FREQ_W-1:0]));
			REG_ORDER_LOG2:   order_sel   = val[2:0];
			REG_POINT_OFFSET: offset_turn = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_FREQ_MIN, REG_FREQ_MAX: mask = 32'h00FF_FFFF;
			REG_ORDER_LOG2:             mask = 32'h0000_0007;
			default:                    mask = 32'h0000_FFFF;
		endcase
		n_reads++;
		if ((prdata & mask) !== (val & mask)) begin
			$error("register %s readback: expected %0h, got %0h", idx.name(), val & mask,
				prdata & mask);
			fault_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic queue_sample(input int re, input int im);
		sample_t s;
		s.re = SW'(re);
		s.im = SW'(im);
		pending.push_back(s);
	endtask

	// hold the sender until every outstanding result has come back
	task automatic wait_drained();
		while (pending.size() != 0 || in_valid || derot_q.size() != 0)
			@(posedge clk);
	endtask

	// reprogram the loop, then send PSK symbols with some noise and rail hits
	task automatic run_phase(input logic [15:0] alpha, input logic [15:0] beta,
			input logic [FREQ_W-1:0] lo, input logic [FREQ_W-1:0] hi,
			input logic [2:0] ord, input logic [15:0] offs, input int count, input int odds);
		int  lg;
		int  k;
		int  nz;
		int  vi;
		int  vq;
		real amp;
		real th;
		wait_drained();
		reg_program(REG_PROP_GAIN, DATA_W'(alpha));
		reg_program(REG_INTEG_GAIN, DATA_W'(beta));
		reg_program(REG_FREQ_MIN, DATA_W'(lo));
		reg_program(REG_FREQ_MAX, DATA_W'(hi));
		reg_program(REG_ORDER_LOG2, DATA_W'(ord));
		reg_program(REG_POINT_OFFSET, DATA_W'(offs));
		n_settings++;
		lg = (ord < 3'd1) ? 1 : (ord > 3'd4) ? 4 : int'(ord);
		carrier_step = (real'($urandom_range(0, 4000)) - 2000.0) * 1.0e-6;
		@(posedge clk);
		idle_odds = odds;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 85) begin
				// a constellation point on a drifting carrier
				amp = 4000.0 + real'($urandom_range(0, 28800));
				th  = carrier_turn + real'(offs) / 65536.0
					+ real'($urandom_range(0, (1 << lg) - 1)) / real'(1 << lg);
				carrier_turn += carrier_step;
				carrier_turn -= $floor(carrier_turn);
				nz = $urandom_range(0, 800);
				vi = $rtoi(amp * $cos(TWO_PI * th)) + int'($urandom_range(0, 2 * nz)) - nz;
				vq = $rtoi(amp * $sin(TWO_PI * th)) + int'($urandom_range(0, 2 * nz)) - nz;
				vi = (vi > SMAX) ? SMAX : (vi < SMIN) ? SMIN : vi;
				vq = (vq > SMAX) ? SMAX : (vq < SMIN) ? SMIN : vq;
			end else if ($urandom_range(0, 3) == 0) begin
				// full-scale corners
				vi = $urandom_range(0, 1) ? SMAX : SMIN;
				vq = $urandom_range(0, 1) ? SMAX : SMIN;
			end else begin
				vi = int'($urandom_range(0, 65535)) - 32768;
				vq = int'($urandom_range(0, 65535)) - 32768;
			end
			queue_sample(vi, vq);
		end
	endtask

	// offer requests and hold off results in random bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || req_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
					send_gap = $urandom_range(0, 12);
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					next_sample = pending.pop_front();
					in_i     <= next_sample.re;
					in_q     <= next_sample.im;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (hold_gap > 0) begin
				hold_gap--;
				out_ready <= 1'b0;
			end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
				hold_gap = $urandom_range(0, 12);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// predict each accepted request and check each result against the oldest
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken = in_valid && in_ready;
			if (in_valid && in_ready) begin
				next_sample.re = in_i;
				next_sample.im = in_q;
				derot_q.push_back(track_sample(next_sample));
				n_samples++;
			end
			if (out_valid && out_ready) begin
				n_results++;
				if (derot_q.size() == 0) begin
					$error("result with no request outstanding");
					fault_count++;
				end else begin
					want = derot_q.pop_front();
					if (out_i !== want.rot_i) begin
						$error("out_i mismatch: expected %0d, got %0d", want.rot_i, out_i);
						fault_count++;
					end
					if (out_q !== want.rot_q) begin
						$error("out_q mismatch: expected %0d, got %0d", want.rot_q, out_q);
						fault_count++;
					end
					if (phase_error !== want.err) begin
						$error("phase_error mismatch: expected %0d, got %0d", want.err,
							phase_error);
						fault_count++;
					end
					if (loop_freq !== want.freq) begin
						$error("loop_freq mismatch: expected %0d, got %0d", want.freq,
							loop_freq);
						fault_count++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, zero gains: the phase stays put, so angles are known
		queue_sample(0, 0);
		queue_sample(SMAX, 0);
		queue_sample(SMIN, 0);
		queue_sample(0, SMAX);
		queue_sample(0, SMIN);
		queue_sample(SMAX, SMAX);
		queue_sample(SMIN, SMIN);
		queue_sample(SMAX, SMIN);
		queue_sample(SMIN, SMAX);
		queue_sample(1, 0);
		queue_sample(-1, -1);
		queue_sample(23170, 23170);
		queue_sample(-23170, 23170);
		queue_sample(16384, 0);
		queue_sample(21845, -21846);
		queue_sample(-21846, 21845);
		queue_sample(0, 1);

		// moderate loop, default constellation
		run_phase(16'd1200, 16'd40, 24'h80_0000, 24'h7F_FFFF, 3'd2, 16'd8192, 150, 8);
		// largest gains, widest clamp, order above range, top offset
		run_phase(16'hFFFF, 16'hFFFF, 24'h80_0000, 24'h7F_FFFF, 3'd7, 16'hFFFF, 120, 4);
		// open loop, order zero acts as BPSK, zero offset
		run_phase(16'd0, 16'd0, 24'h80_0000, 24'h7F_FFFF, 3'd0, 16'd0, 100, 10);
		// crossed clamp limits
		run_phase(16'd3000, 16'd400, 24'(5000), 24'(-5000), 3'd3, 16'($urandom), 150, 5);
		// frequency pinned at zero, BPSK
		run_phase(16'd800, 16'd3000, 24'd0, 24'd0, 3'd1, 16'($urandom), 120, 3);
		// 16-PSK with a narrow clamp
		run_phase(16'd2500, 16'd120, 24'(-20000), 24'd20000, 3'd4, 16'd2048, 140, 7);
		repeat (3)
			run_phase(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
				3'($urandom), 16'($urandom), 150, $urandom_range(2, 12));
		// steady finish with no idling
		run_phase(16'd1500, 16'd60, 24'(-100000), 24'd100000, 3'd3, 16'd4096, 120, 0);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Loop checked on %0d samples, %0d results, %0d register settings", n_samples,
			n_results, n_settings);
		$display("with %0d register readbacks and %0d faults seen", n_reads, fault_count);
		if (fault_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: decision_directed_carrier_pll_top.f
rtl/dcpll_pkg.sv
rtl/dcpll_regs.sv
rtl/dcpll_cordic.sv
rtl/decision_directed_carrier_pll_top.sv
test/decision_directed_carrier_pll_top_test.sv
